>>> design/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

   localparam int MAX_SLOTS  = 1024;
   localparam int WORD_BITS  = 32;
   localparam int NUM_WORDS  = MAX_SLOTS / WORD_BITS;
   localparam int BIT_AW     = $clog2(WORD_BITS);
   localparam int WORD_AW    = $clog2(NUM_WORDS);
   localparam int IDX_W      = 10;
   localparam int CAP_W      = 11;
   localparam int OBJ_W      = 16;
   localparam int OFS_W      = 26;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJ_SIZE = 1'd1;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_SLOTS);
   localparam logic [OBJ_W-1:0] OBJ_RESET = OBJ_W'(1);

   localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] S_DISP   = 3'd1;
   localparam logic [STEP_W-1:0] S_ASTART = 3'd2;
   localparam logic [STEP_W-1:0] S_SCAN   = 3'd3;
   localparam logic [STEP_W-1:0] S_FCHK   = 3'd4;
   localparam logic [STEP_W-1:0] S_FWR    = 3'd5;
   localparam logic [STEP_W-1:0] S_MUL    = 3'd6;
   localparam logic [STEP_W-1:0] S_OUT    = 3'd7;

   localparam int ACT_W = 3;
   localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_IDLE   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_ASTART = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SCAN   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FCHK   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FWR    = 3'd5;
   localparam logic [ACT_W-1:0] ACT_MUL    = 3'd6;
   localparam logic [ACT_W-1:0] ACT_OUT    = 3'd7;

   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] CND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] CND_NOREQ    = 3'd1;
   localparam logic [COND_W-1:0] CND_FREE     = 3'd2;
   localparam logic [COND_W-1:0] CND_CONT     = 3'd3;
   localparam logic [COND_W-1:0] CND_RANGE    = 3'd4;
   localparam logic [COND_W-1:0] CND_OUT_BUSY = 3'd5;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
      logic [STEP_W-1:0] next;
   } ctl_type;

   typedef struct packed {
      logic [WORD_AW-1:0]   rd_addr;
      logic                 wr_en;
      logic [WORD_AW-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } mem_req_type;

   function automatic ctl_type ucode(input logic [STEP_W-1:0] step);
      ctl_type c;
      case (step)
         S_IDLE:   c = '{ACT_IDLE,   CND_NOREQ,    S_IDLE,   S_DISP};
         S_DISP:   c = '{ACT_NONE,   CND_FREE,     S_FCHK,   S_ASTART};
         S_ASTART: c = '{ACT_ASTART, CND_NEVER,    S_IDLE,   S_SCAN};
         S_SCAN:   c = '{ACT_SCAN,   CND_CONT,     S_SCAN,   S_MUL};
         S_FCHK:   c = '{ACT_FCHK,   CND_RANGE,    S_MUL,    S_FWR};
         S_FWR:    c = '{ACT_FWR,    CND_NEVER,    S_IDLE,   S_MUL};
         S_MUL:    c = '{ACT_MUL,    CND_NEVER,    S_IDLE,   S_OUT};
         S_OUT:    c = '{ACT_OUT,    CND_OUT_BUSY, S_OUT,    S_IDLE};
         default:  c = '{ACT_NONE,   CND_NEVER,    S_IDLE,   S_IDLE};
      endcase
      return c;
   endfunction

endpackage

>>> design/bsa_bitmap.sv
`timescale 1ns / 1ps

module bsa_bitmap (
   input  logic                          clock,
   input  logic                          reset,
   input  bsa_pkg::mem_req_type          mem_req,
   output logic [bsa_pkg::WORD_BITS-1:0] rd_word
);
   import bsa_pkg::*;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [NUM_WORDS-1:0] vld_ff;
   logic [NUM_WORDS-1:0] vld_in;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   always_comb begin
      vld_in = vld_ff;
      if (mem_req.wr_en) begin
         vld_in[mem_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[mem_req.rd_addr];
      end
   end

   assign rd_word = rd_vld_ff ? rd_data_ff : '0;

endmodule

>>> design/bitmap_slot_allocator_core.sv
`timescale 1ns / 1ps

// First-fit slot allocator over a 1024-slot bitmap held in 32 words of 32 bits.
// One transaction is worked at a time by a small microcoded sequencer. An
// allocate scans one bitmap word per cycle through the single read port of the
// bitmap memory, 1 to 32 words up to the first free slot or to the capacity
// limit; the next request is taken in the cycle after the response is loaded.
// The response register holds a finished result while the next request is
// worked. The bitmap is empty right after reset, with no clearing pass.
// Registers: index 0 capacity (11 bits, above 1024 acts as 1024), index 1
// object size (16 bits); write them only while idle.

module bitmap_slot_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [bsa_pkg::IDX_W-1:0]      req_free_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bsa_pkg::STAT_W-1:0]     rsp_status,
   output logic [bsa_pkg::IDX_W-1:0]      rsp_slot_index,
   output logic [bsa_pkg::OFS_W-1:0]      rsp_byte_offset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bsa_pkg::*;

   logic [STEP_W-1:0]    step_ff;
   logic [STEP_W-1:0]    step_in;
   ctl_type              ctl;
   logic                 cond_true;

   logic [CAP_W-1:0]     cap_ff;
   logic [OBJ_W-1:0]     obj_ff;
   logic [CAP_W-1:0]     cap_eff;

   logic                 mode_ff;
   logic [IDX_W-1:0]     fidx_ff;
   logic [WORD_AW-1:0]   ptr_ff;
   logic [STAT_W-1:0]    res_stat_ff;
   logic [IDX_W-1:0]     res_idx_ff;
   logic [OFS_W-1:0]     res_ofs_ff;

   logic                 rsp_valid_ff;
   logic [STAT_W-1:0]    rsp_stat_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic [OFS_W-1:0]     rsp_ofs_ff;

   mem_req_type          mem_req;
   logic [WORD_BITS-1:0] rd_word;

   logic [WORD_BITS-1:0] cap_mask;
   logic [WORD_BITS-1:0] avail;
   logic [WORD_BITS-1:0] onehot;
   logic [BIT_AW-1:0]    hit_bit;
   logic                 hit;
   logic                 last_word;
   logic                 idx_range;
   logic                 out_free;

   bsa_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

   assign ctl       = ucode(step_ff);
   assign req_ready = (ctl.act == ACT_IDLE);
   assign csr_ready = 1'b1;
   assign cap_eff   = (cap_ff > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : cap_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_range = ({1'b0, fidx_ff} >= cap_eff);

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         cap_mask[b] = ({1'b0, ptr_ff, BIT_AW'(b)} < cap_eff);
      end
   end

   assign avail     = ~rd_word & cap_mask;
   assign onehot    = avail & (~avail + WORD_BITS'(1));
   assign hit       = |avail;
   assign last_word = ({({1'b0, ptr_ff} + (WORD_AW + 1)'(1)), BIT_AW'(0)} >= cap_eff);

   always_comb begin
      hit_bit = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (onehot[b]) begin
            hit_bit = hit_bit | BIT_AW'(b);
         end
      end
   end

   always_comb begin
      case (ctl.cond)
         CND_NEVER:    cond_true = 1'b0;
         CND_NOREQ:    cond_true = !req_valid;
         CND_FREE:     cond_true = mode_ff;
         CND_CONT:     cond_true = !hit && !last_word;
         CND_RANGE:    cond_true = idx_range;
         CND_OUT_BUSY: cond_true = !out_free;
         default:      cond_true = 1'b0;
      endcase
      step_in = cond_true ? ctl.target : ctl.next;
   end

   always_comb begin
      mem_req.rd_addr = ptr_ff + WORD_AW'(1);
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ptr_ff;
      mem_req.wr_data = rd_word | onehot;
      case (ctl.act)
         ACT_ASTART: begin
            mem_req.rd_addr = '0;
         end
         ACT_SCAN: begin
            mem_req.wr_en = hit;
         end
         ACT_FCHK: begin
            mem_req.rd_addr = fidx_ff[IDX_W-1:BIT_AW];
         end
         ACT_FWR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = fidx_ff[IDX_W-1:BIT_AW];
            mem_req.wr_data = rd_word & ~(WORD_BITS'(1) << fidx_ff[BIT_AW-1:0]);
         end
         default: begin
            mem_req.wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_IDLE;
         cap_ff       <= CAP_RESET;
         obj_ff       <= OBJ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff <= csr_wdata[CAP_W-1:0];
               CSR_OBJ_SIZE: obj_ff <= csr_wdata[OBJ_W-1:0];
               default:      cap_ff <= cap_ff;
            endcase
         end
         if (ctl.act == ACT_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.act)
         ACT_IDLE: begin
            if (req_valid) begin
               mode_ff <= req_mode;
               fidx_ff <= req_free_index;
            end
         end
         ACT_ASTART: begin
            ptr_ff <= '0;
         end
         ACT_SCAN: begin
            if (hit) begin
               res_stat_ff <= ST_ALLOCATED;
               res_idx_ff  <= {ptr_ff, hit_bit};
            end else if (last_word) begin
               res_stat_ff <= ST_FULL;
               res_idx_ff  <= '0;
            end else begin
               ptr_ff <= ptr_ff + WORD_AW'(1);
            end
         end
         ACT_FCHK: begin
            res_stat_ff <= idx_range ? ST_RANGE : ST_FREED;
            res_idx_ff  <= idx_range ? '0 : fidx_ff;
         end
         ACT_MUL: begin
            res_ofs_ff <= OFS_W'(res_idx_ff) * OFS_W'(obj_ff);
         end
         ACT_OUT: begin
            if (out_free) begin
               rsp_stat_ff <= res_stat_ff;
               rsp_idx_ff  <= res_idx_ff;
               rsp_ofs_ff  <= res_ofs_ff;
            end
         end
         default: begin
            ptr_ff <= ptr_ff;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_stat_ff;
   assign rsp_slot_index  = rsp_idx_ff;
   assign rsp_byte_offset = rsp_ofs_ff;

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (step_ff == S_DISP))
      else $error("accepted request did not advance to dispatch");

   a_alloc_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ALLOCATED) |-> ({1'b0, rsp_slot_index} < cap_eff))
      else $error("allocated index at or above capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_RANGE))
      |-> (rsp_slot_index == '0 && rsp_byte_offset == '0))
      else $error("failed transaction carries nonzero index or offset");

endmodule
